FILE: hdl/assert_macros.svh
// Assertion macros shared by the buffer manager RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define BOM_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define BOM_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bom_pkg.sv
// Types and constants of the buffer ownership manager.
package bom_pkg;

  localparam int ID_W     = 4;
  localparam int ID_SPACE = 16;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 3;
  localparam int CMD_W    = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQ_FREE   = 4'd0,
    CMD_SUBMIT     = 4'd1,
    CMD_REL_FREE   = 4'd2,
    CMD_ACQ_FILLED = 4'd3,
    CMD_REL_FILLED = 4'd4,
    CMD_ADD_FREE   = 4'd5,
    CMD_ADD_FILLED = 4'd6,
    CMD_REMOVE     = 4'd7,
    CMD_SHUTDOWN   = 4'd8,
    CMD_CLEAR      = 4'd9
  } bom_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 3'd0,
    STS_EMPTY   = 3'd1,
    STS_NOTMEM  = 3'd2,
    STS_WRONG   = 3'd3,
    STS_ALREADY = 3'd4,
    STS_NOTQ    = 3'd5,
    STS_SHUT    = 3'd6,
    STS_FULL    = 3'd7
  } bom_status_t;

  typedef enum logic [1:0] {
    OWN_IDLE  = 2'd0,
    OWN_PROD  = 2'd1,
    OWN_READY = 2'd2,
    OWN_CONS  = 2'd3
  } bom_own_t;

  // Operation broadcast to every cell of a queue; tag is push data or kill key.
  typedef struct packed {
    logic            push;
    logic            pop;
    logic            kill;
    logic [ID_W-1:0] tag;
  } bom_qop_t;

  typedef struct packed {
    logic [ID_W-1:0] head;
    logic            hit;
    logic            empty;
    logic            full;
  } bom_qstat_t;

endpackage

FILE: hdl/bom_cell.sv
// One queue cell: holds an id and shifts it towards the head on pop or kill.
module bom_cell (
  input  logic                  clk,
  input  logic                  occ,
  input  logic                  tail,
  input  bom_pkg::bom_qop_t     op,
  input  logic                  hit_in,
  input  logic [bom_pkg::ID_W-1:0] nxt_id,
  output logic [bom_pkg::ID_W-1:0] id,
  output logic                  hit_out
);
  import bom_pkg::*;

  logic match;
  logic shift;
  logic load;

  assign match   = occ && (id == op.tag);
  assign hit_out = hit_in | match;
  // cells at and behind the first match close up over it
  assign shift   = op.pop | (op.kill & hit_out);
  assign load    = op.push & tail;

  always_ff @(posedge clk) begin
    if (load) begin
      id <= op.tag;
    end else if (shift) begin
      id <= nxt_id;
    end
  end

endmodule

FILE: hdl/bom_queue.sv
// Id queue built as a row of cells with a length counter.
`include "assert_macros.svh"

module bom_queue #(
  parameter int NUM_BUFFERS = 16,
  parameter int LEN_W       = $clog2(NUM_BUFFERS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  bom_pkg::bom_qop_t   op,
  output bom_pkg::bom_qstat_t stat,
  output logic [LEN_W-1:0]    len,
  output logic [LEN_W-1:0]    len_next
);
  import bom_pkg::*;

  logic [ID_W-1:0] cell_id  [NUM_BUFFERS];
  logic            cell_hit [NUM_BUFFERS];

  for (genvar i = 0; i < NUM_BUFFERS; i++) begin : g_cell
    logic            occ;
    logic            tail;
    logic            hit_in;
    logic [ID_W-1:0] nxt_id;

    assign occ  = LEN_W'(i) < len;
    assign tail = LEN_W'(i) == len;

    if (i == 0) begin : g_first
      assign hit_in = 1'b0;
    end else begin : g_rest
      assign hit_in = cell_hit[i-1];
    end

    if (i == NUM_BUFFERS - 1) begin : g_last
      assign nxt_id = cell_id[i];
    end else begin : g_mid
      assign nxt_id = cell_id[i+1];
    end

    bom_cell u_cell (
      .clk     (clk),
      .occ     (occ),
      .tail    (tail),
      .op      (op),
      .hit_in  (hit_in),
      .nxt_id  (nxt_id),
      .id      (cell_id[i]),
      .hit_out (cell_hit[i])
    );
  end

  assign stat.head  = cell_id[0];
  assign stat.hit   = cell_hit[NUM_BUFFERS-1];
  assign stat.empty = (len == '0);
  assign stat.full  = (len == LEN_W'(NUM_BUFFERS));

  always_comb begin
    len_next = len;
    if (op.push) begin
      len_next = len + 1'b1;
    end else if (op.pop || (op.kill && stat.hit)) begin
      len_next = len - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else begin
      len <= len_next;
    end
  end

  `BOM_HOLDS(a_len_bound, 32'(len) <= NUM_BUFFERS, "queue length beyond depth")

endmodule

FILE: hdl/buffer_ownership_manager.sv
// Buffer ownership manager top level: command decode, ownership and membership.
// Each request carries a command and a buffer id and yields exactly one result
// with status, granted id, queue counts, member count and running flag. Every
// command but a remove is answered from the idle state; a remove kills one copy
// of the id, then sweeps out each further copy held in the free queue, as its
// cell row closes up over one copy per cycle. A new request is taken while the
// previous result still waits in the output register, if that register is
// free by the next edge. Ids at or above NUM_BUFFERS are refused as non-members.
`include "assert_macros.svh"

module buffer_ownership_manager #(
  parameter int NUM_BUFFERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // cmd[3:0], buffer_id[7:4]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status[2:0], granted_id[6:3], free_count[11:7],
                                 // filled_count[16:12], member_count[21:17],
                                 // pool_running[22], zero[23]
);
  import bom_pkg::*;

  localparam int LEN_W = $clog2(NUM_BUFFERS + 1);

  typedef enum logic {S_IDLE, S_SWEEP} state_t;

  state_t              state, state_next;
  bom_cmd_t            cmd;
  logic [ID_W-1:0]     buffer_id;
  logic                accept;
  logic                slot_free;

  bom_qop_t            free_op, filled_op;
  bom_qstat_t          free_stat, filled_stat;
  logic [LEN_W-1:0]    free_len, free_len_next;
  logic [LEN_W-1:0]    filled_len, filled_len_next;
  logic [LEN_W+COUNT_W-1:0] free_ext, filled_ext;

  bom_own_t            owner [ID_SPACE];
  logic [ID_SPACE-1:0] mark;
  logic [COUNT_W-1:0]  members, members_next;
  logic                running, running_next;
  logic [ID_W-1:0]     rm_id;
  logic [ID_W-1:0]     tag;

  logic                in_range, is_mem;
  bom_own_t            cur_own;

  logic                res_load;
  bom_status_t         res_status;
  logic [ID_W-1:0]     res_grant;
  logic                owner_we;
  logic [ID_W-1:0]     owner_wa;
  bom_own_t            owner_wd;
  logic                mark_set, mark_clr, mark_clr_all;
  logic                rm_load;

  assign cmd       = bom_cmd_t'(s_tdata[3:0]);
  assign buffer_id = s_tdata[7:4];
  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && slot_free;
  assign accept    = s_tvalid && s_tready;

  assign tag      = (state == S_SWEEP) ? rm_id : buffer_id;
  assign in_range = 32'(tag) < NUM_BUFFERS;
  assign is_mem   = in_range && mark[tag];
  assign cur_own  = owner[tag];

  bom_queue #(.NUM_BUFFERS(NUM_BUFFERS), .LEN_W(LEN_W)) u_free_q (
    .clk      (clk),
    .rst      (rst),
    .op       (free_op),
    .stat     (free_stat),
    .len      (free_len),
    .len_next (free_len_next)
  );

  bom_queue #(.NUM_BUFFERS(NUM_BUFFERS), .LEN_W(LEN_W)) u_filled_q (
    .clk      (clk),
    .rst      (rst),
    .op       (filled_op),
    .stat     (filled_stat),
    .len      (filled_len),
    .len_next (filled_len_next)
  );

  assign free_ext   = {{COUNT_W{1'b0}}, free_len_next};
  assign filled_ext = {{COUNT_W{1'b0}}, filled_len_next};

  always_comb begin
    free_op        = '0;
    filled_op      = '0;
    free_op.tag    = tag;
    filled_op.tag  = tag;
    res_load       = 1'b0;
    res_status     = STS_OK;
    res_grant      = '0;
    owner_we       = 1'b0;
    owner_wa       = tag;
    owner_wd       = OWN_IDLE;
    mark_set       = 1'b0;
    mark_clr       = 1'b0;
    mark_clr_all   = 1'b0;
    members_next   = members;
    running_next   = running;
    state_next     = state;
    rm_load        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          unique case (cmd) inside
            CMD_ACQ_FREE: begin
              if (!running) begin
                res_status = STS_SHUT;
              end else if (free_stat.empty) begin
                res_status = STS_EMPTY;
              end else begin
                free_op.pop = 1'b1;
                res_grant   = free_stat.head;
                owner_we    = 1'b1;
                owner_wa    = free_stat.head;
                owner_wd    = OWN_PROD;
              end
            end
            CMD_ACQ_FILLED: begin
              if (filled_stat.empty) begin
                res_status = STS_EMPTY;
              end else begin
                filled_op.pop = 1'b1;
                res_grant     = filled_stat.head;
                owner_we      = 1'b1;
                owner_wa      = filled_stat.head;
                owner_wd      = OWN_CONS;
              end
            end
            CMD_SUBMIT: begin
              if (!is_mem) begin
                res_status = STS_NOTMEM;
              end else if (cur_own != OWN_PROD) begin
                res_status = STS_WRONG;
              end else if (filled_stat.full) begin
                res_status = STS_FULL;
              end else begin
                filled_op.push = 1'b1;
                owner_we       = 1'b1;
                owner_wd       = OWN_READY;
              end
            end
            CMD_REL_FREE, CMD_REL_FILLED: begin
              if (!is_mem) begin
                res_status = STS_NOTMEM;
              end else if (cur_own != ((cmd == CMD_REL_FREE) ? OWN_PROD : OWN_CONS)) begin
                res_status = STS_WRONG;
              end else if (free_stat.full) begin
                res_status = STS_FULL;
              end else begin
                free_op.push = 1'b1;
                owner_we     = 1'b1;
                owner_wd     = OWN_IDLE;
              end
            end
            CMD_ADD_FREE: begin
              if (!in_range) begin
                res_status = STS_NOTMEM;
              end else if (mark[tag]) begin
                res_status = STS_ALREADY;
              end else if (free_stat.full) begin
                res_status = STS_FULL;
              end else begin
                free_op.push = 1'b1;
                mark_set     = 1'b1;
                members_next = members + 1'b1;
                owner_we     = 1'b1;
                owner_wd     = OWN_IDLE;
              end
            end
            CMD_ADD_FILLED: begin
              if (!in_range) begin
                res_status = STS_NOTMEM;
              end else if (mark[tag]) begin
                res_status = STS_ALREADY;
              end else if (filled_stat.full) begin
                res_status = STS_FULL;
              end else begin
                filled_op.push = 1'b1;
                mark_set       = 1'b1;
                members_next   = members + 1'b1;
                owner_we       = 1'b1;
                owner_wd       = OWN_READY;
              end
            end
            CMD_REMOVE: begin
              if (!is_mem) begin
                res_status = STS_NOTMEM;
              end else if (cur_own != OWN_IDLE) begin
                res_status = STS_WRONG;
              end else if (!free_stat.hit) begin
                res_status = STS_NOTQ;
              end else begin
                // first copy goes now, the rest in the sweep
                free_op.kill = 1'b1;
                res_load     = 1'b0;
                rm_load      = 1'b1;
                state_next   = S_SWEEP;
              end
            end
            CMD_SHUTDOWN: begin
              running_next = 1'b0;
            end
            CMD_CLEAR: begin
              mark_clr_all = 1'b1;
              members_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SWEEP: begin
        if (free_stat.hit) begin
          free_op.kill = 1'b1;
        end else if (slot_free) begin
          res_load     = 1'b1;
          mark_clr     = 1'b1;
          members_next = members - 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      state <= state_next;
      if (res_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {1'b0, running_next, members_next, filled_ext[COUNT_W-1:0],
                     free_ext[COUNT_W-1:0], res_grant, res_status};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mark    <= '0;
      members <= '0;
      running <= 1'b1;
    end else begin
      members <= members_next;
      running <= running_next;
      if (mark_clr_all) begin
        mark <= '0;
      end else if (mark_set) begin
        mark[tag] <= 1'b1;
      end else if (mark_clr) begin
        mark[tag] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (owner_we) begin
      owner[owner_wa] <= owner_wd;
    end
    if (rm_load) begin
      rm_id <= buffer_id;
    end
  end

  `BOM_HOLDS(a_member_count, $countones(mark) == 32'(members), "member count out of step")
  `BOM_NEXT(a_sweep_drop, (state == S_SWEEP) && free_stat.hit,
            free_len == $past(free_len) - 1'b1, "sweep did not drop a copy")

endmodule

FILE: test/tb.sv
// Self-checking testbench of the buffer ownership manager: random commands against a predictor.
module tb;
  import bom_pkg::*;

  localparam int RANDOM_END  = 510;   // requests issued before the shutdown tail
  localparam int TOTAL_REQS  = 550;
  localparam int HOLD_AT     = 150;   // results taken before the long receiver hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 40;

  // Command codes with no function; the block answers them with ok.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd10;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

  typedef struct {
    bom_status_t        status;
    logic [ID_W-1:0]    granted;
    logic [COUNT_W-1:0] free_count;
    logic [COUNT_W-1:0] filled_count;
    logic [COUNT_W-1:0] member_count;
    logic               running;
  } bom_outcome_t;

  class bom_scoreboard;
    logic [ID_W-1:0] free_q[$];
    logic [ID_W-1:0] filled_q[$];
    bom_own_t        owner[ID_SPACE];
    bit              member[ID_SPACE];
    int              members;
    bit              running;
    bom_outcome_t    due[$];
    int              fails;

    function new();
      foreach (owner[i]) begin
        owner[i]  = OWN_IDLE;
        member[i] = 1'b0;
      end
      members = 0;
      running = 1'b1;
      fails   = 0;
    endfunction

    function bit is_full(bit to_filled);
      return to_filled ? (filled_q.size() >= ID_SPACE) : (free_q.size() >= ID_SPACE);
    endfunction

    function void enqueue(bit to_filled, logic [ID_W-1:0] id);
      if (to_filled) filled_q.push_back(id);
      else free_q.push_back(id);
    endfunction

    // Submit and both releases: membership, then state, then room.
    function bom_status_t hand_back(logic [ID_W-1:0] id, bom_own_t need, bit to_filled,
                                    bom_own_t next);
      if (!member[id]) return STS_NOTMEM;
      if (owner[id] != need) return STS_WRONG;
      if (is_full(to_filled)) return STS_FULL;
      enqueue(to_filled, id);
      owner[id] = next;
      return STS_OK;
    endfunction

    function bom_status_t add_to_pool(logic [ID_W-1:0] id, bit to_filled, bom_own_t next);
      if (member[id]) return STS_ALREADY;
      if (is_full(to_filled)) return STS_FULL;
      member[id] = 1'b1;
      members++;
      enqueue(to_filled, id);
      owner[id] = next;
      return STS_OK;
    endfunction

    // Every copy of the id leaves the free queue.
    function bom_status_t take_out(logic [ID_W-1:0] id);
      logic [ID_W-1:0] kept[$];
      bit found;
      found = 1'b0;
      if (!member[id]) return STS_NOTMEM;
      if (owner[id] != OWN_IDLE) return STS_WRONG;
      foreach (free_q[i]) begin
        if (free_q[i] == id) found = 1'b1;
        else kept.push_back(free_q[i]);
      end
      if (!found) return STS_NOTQ;
      free_q     = kept;
      member[id] = 1'b0;
      members--;
      return STS_OK;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
      bom_outcome_t o;
      o.status  = STS_OK;
      o.granted = '0;
      case (cmd)
        CMD_ACQ_FREE: begin
          if (!running) o.status = STS_SHUT;
          else if (free_q.size() == 0) o.status = STS_EMPTY;
          else begin
            o.granted = free_q.pop_front();
            owner[o.granted] = OWN_PROD;
          end
        end
        CMD_ACQ_FILLED: begin
          if (filled_q.size() == 0) o.status = STS_EMPTY;
          else begin
            o.granted = filled_q.pop_front();
            owner[o.granted] = OWN_CONS;
          end
        end
        CMD_SUBMIT:     o.status = hand_back(id, OWN_PROD, 1'b1, OWN_READY);
        CMD_REL_FREE:   o.status = hand_back(id, OWN_PROD, 1'b0, OWN_IDLE);
        CMD_REL_FILLED: o.status = hand_back(id, OWN_CONS, 1'b0, OWN_IDLE);
        CMD_ADD_FREE:   o.status = add_to_pool(id, 1'b0, OWN_IDLE);
        CMD_ADD_FILLED: o.status = add_to_pool(id, 1'b1, OWN_READY);
        CMD_REMOVE:     o.status = take_out(id);
        CMD_SHUTDOWN:   running = 1'b0;
        CMD_CLEAR: begin
          foreach (member[i]) member[i] = 1'b0;
          members = 0;
        end
        default: ;
      endcase
      o.free_count   = COUNT_W'(free_q.size());
      o.filled_count = COUNT_W'(filled_q.size());
      o.member_count = COUNT_W'(members);
      o.running      = running;
      due.push_back(o);
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(logic [23:0] d);
      bom_outcome_t want;
      if (due.size() == 0) begin
        $error("result %h with no request outstanding", d);
        fails++;
        return;
      end
      want = due.pop_front();
      compare("status", 8'(want.status), 8'(d[2:0]));
      compare("granted_id", 8'(want.granted), 8'(d[6:3]));
      compare("free_count", 8'(want.free_count), 8'(d[11:7]));
      compare("filled_count", 8'(want.filled_count), 8'(d[16:12]));
      compare("member_count", 8'(want.member_count), 8'(d[21:17]));
      compare("pool_running", 8'(want.running), 8'(d[22]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // cmd[3:0], buffer_id[7:4]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // status, granted_id, free/filled/member counts, running

  bom_scoreboard sb = new();
  int sent = 0;
  int taken = 0;
  int quiet = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit held = 1'b0;

  buffer_ownership_manager #(.NUM_BUFFERS(ID_SPACE)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("buffer_ownership_manager: mismatch");
      $finish;
    end
  end

  function automatic logic [ID_W-1:0] any_id();
    return ID_W'($urandom_range(0, ID_SPACE - 1));
  endfunction

  // Mostly a member in the wanted state, so commands get past the checks.
  function automatic logic [ID_W-1:0] held_as(bom_own_t want);
    logic [ID_W-1:0] pick[$];
    for (int i = 0; i < ID_SPACE; i++)
      if (sb.member[i] && sb.owner[i] == want) pick.push_back(ID_W'(i));
    if (pick.size() == 0 || $urandom_range(0, 4) == 0) return any_id();
    return pick[$urandom_range(0, pick.size() - 1)];
  endfunction

  function automatic logic [ID_W-1:0] outsider();
    logic [ID_W-1:0] pick[$];
    for (int i = 0; i < ID_SPACE; i++)
      if (!sb.member[i]) pick.push_back(ID_W'(i));
    if (pick.size() == 0 || $urandom_range(0, 4) == 0) return any_id();
    return pick[$urandom_range(0, pick.size() - 1)];
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {id, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(cmd, id);
    sent++;
  endtask

  task automatic lifecycle_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) send_request(CMD_ACQ_FREE, any_id());
    else if (r < 38) send_request(CMD_SUBMIT, held_as(OWN_PROD));
    else if (r < 55) send_request(CMD_ACQ_FILLED, any_id());
    else if (r < 72) send_request(CMD_REL_FILLED, held_as(OWN_CONS));
    else if (r < 78) send_request(CMD_REL_FREE, held_as(OWN_PROD));
    else if (r < 88) send_request(CMD_ADD_FREE, outsider());
    else if (r < 95) send_request(CMD_REMOVE, held_as(OWN_IDLE));
    else send_request(CMD_ADD_FILLED, outsider());
  endtask

  task automatic flood_step();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) send_request(CMD_CLEAR, any_id());
    else if (r < 12) send_request(CMD_ADD_FREE, any_id());
    else send_request(CMD_ADD_FILLED, any_id());
  endtask

  task automatic drain_step();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) send_request(CMD_ACQ_FILLED, any_id());
    else if (r == 1) send_request(CMD_REL_FILLED, held_as(OWN_CONS));
    else if (r == 2) send_request(CMD_ACQ_FREE, any_id());
    else send_request(CMD_REL_FREE, held_as(OWN_PROD));
  endtask

  // Receiver: random back-pressure, one long hold-off so the block backs up.
  initial begin
    int w;
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT && !held) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      w = rx_idle ? $urandom_range(0, 9) : 0;
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata);
      taken++;
      if (taken % 25 == 0) rx_idle = ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty queues, non-members, wrong states, duplicates after clear.
    send_request(CMD_ACQ_FREE, 4'd0);
    send_request(CMD_ACQ_FILLED, 4'd0);
    send_request(CMD_SUBMIT, 4'd0);
    send_request(CMD_REL_FILLED, 4'd15);
    send_request(CMD_REMOVE, 4'd7);
    send_request(CMD_ADD_FREE, 4'd0);
    send_request(CMD_ADD_FREE, 4'd15);
    send_request(CMD_ADD_FILLED, 4'd9);
    send_request(CMD_ADD_FREE, 4'd0);
    send_request(CMD_ADD_FILLED, 4'd9);
    send_request(CMD_SUBMIT, 4'd0);
    send_request(CMD_ACQ_FREE, 4'd0);
    send_request(CMD_REL_FILLED, 4'd0);
    send_request(CMD_REMOVE, 4'd0);
    send_request(CMD_SUBMIT, 4'd0);
    send_request(CMD_ACQ_FILLED, 4'd0);
    send_request(CMD_REL_FREE, 4'd9);
    send_request(CMD_REL_FILLED, 4'd9);
    send_request(CMD_REMOVE, 4'd15);
    send_request(CMD_SPARE_LO, 4'd5);
    send_request(CMD_SPARE_HI, 4'd10);
    send_request(CMD_CLEAR, 4'd0);
    send_request(CMD_ADD_FREE, 4'd9);
    send_request(CMD_REMOVE, 4'd9);   // two copies to close over

    while (sent < RANDOM_END) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: repeat (12) lifecycle_step();
        5, 6: repeat (10) flood_step();
        7: repeat (8) send_request(CMD_W'($urandom_range(0, 15)), any_id());
        8: repeat (8) drain_step();
        default: begin
          send_request(CMD_CLEAR, any_id());
          repeat (6) send_request(CMD_ADD_FREE, any_id());
        end
      endcase
    end

    // After shutdown only the filled side may still hand out buffers.
    send_request(CMD_SHUTDOWN, any_id());
    send_request(CMD_ACQ_FREE, any_id());
    send_request(CMD_SHUTDOWN, any_id());
    while (sent < TOTAL_REQS) begin
      tx_idle = ($urandom_range(0, 1) != 0);
      repeat (8) lifecycle_step();
    end

    s_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.fails == 0) $display("buffer_ownership_manager: match");
    else $display("buffer_ownership_manager: mismatch");
    $finish;
  end
endmodule
